// ----- rtl/core/lsat_pkg.sv -----
package lsat_pkg;

  localparam int CHANNELS        = 8;
  localparam int SAMPLE_BITS     = 12;
  localparam int DEBOUNCE_FRAMES = 8;

  localparam int CH_W     = $clog2(CHANNELS);
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int DCNT_W   = 4;
  localparam int DARK_W   = 16;
  localparam int ERR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int THR_W    = 4;
  localparam int IDX_W    = 3;
  localparam int DEB_W    = 4;
  localparam int EVT_W    = 16;
  localparam int FRAC_Q15 = 15;

  localparam logic [DARK_W-1:0]       ONE_Q15  = 16'h8000;
  localparam logic [DARK_W-1:0]       HALF_Q15 = 16'h4000;
  localparam logic signed [ERR_W-1:0] ONE_Q14  = 16'sd16384;
  localparam logic signed [ERR_W-1:0] DIR_BAND = 16'sd819;

  localparam logic [SAMPLE_BITS-1:0] WHITE_RESET = SAMPLE_BITS'(3500);
  localparam logic [SAMPLE_BITS-1:0] BLACK_RESET = SAMPLE_BITS'(500);
  localparam logic [CFG_W-1:0]       ALPHA_RESET = 16'd19661;
  localparam logic [THR_W-1:0]       THR_RESET   = 4'd6;
  localparam logic [CFG_W-1:0]       FLOOR_RESET = 16'd4915;

  localparam int NUM_BITS   = SAMPLE_BITS + FRAC_Q15;
  localparam int LDIV_CNT_W = $clog2(NUM_BITS);

  localparam int SUM_W      = DARK_W + CH_W;
  localparam int WSUM_W     = DARK_W + 2 * CH_W + 1;
  localparam int DEN_W      = SUM_W + CH_W;
  localparam int CEN_D_W    = DEN_W + 1;
  localparam int CEN_N_W    = WSUM_W + 16;
  localparam int CDIV_CNT_W = $clog2(CEN_N_W);

  localparam int P1_W      = 2 * ERR_W;
  localparam int P2_W      = 3 * ERR_W;
  localparam int CUB_SPLIT = 24;
  localparam int ACC_W     = 64;
  localparam int CUB_SHIFT = 43;
  localparam int LIN_SHIFT = 28;
  localparam int FPROD_W   = 2 * CFG_W;

  typedef enum logic [1:0] {
    MODE_ANALOG    = 2'd0,
    MODE_DIGITAL   = 2'd1,
    MODE_CAL_WHITE = 2'd2,
    MODE_CAL_BLACK = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LINE_ON    = 2'd0,
    LINE_LOST  = 2'd1,
    LINE_CROSS = 2'd2
  } line_e;

  typedef enum logic [IDX_W-1:0] {
    REG_ALPHA  = 3'd0,
    REG_THR    = 3'd1,
    REG_INVERT = 3'd2,
    REG_FLOOR  = 3'd3,
    REG_MEDIAN = 3'd4,
    REG_CUBIC  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    MST_IDLE,
    MST_LANES,
    MST_SUM,
    MST_CLASS,
    MST_DIV,
    MST_DIV_END,
    MST_CUB_SQ,
    MST_CUB_CU,
    MST_CUB_LO,
    MST_CUB_HI,
    MST_CUB_END,
    MST_FILT_MUL,
    MST_FILT_ADD,
    MST_EMIT
  } mst_e;

  typedef struct packed {
    logic [CFG_W-1:0] alpha;
    logic [THR_W-1:0] thr;
    logic             invert;
    logic [CFG_W-1:0] floor_lvl;
    logic             median;
    logic [CFG_W-1:0] cubic;
  } cfg_t;

  typedef struct packed {
    logic             start;
    mode_e            mode;
    logic             seeded;
    logic             median;
    logic             invert;
    logic [CFG_W-1:0] floor_lvl;
  } lane_cmd_t;

  typedef struct packed {
    line_e                    state;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  filt;
    logic [DCNT_W-1:0]        dcnt;
    logic [EVT_W-1:0]         events;
  } result_t;

  function automatic logic [SAMPLE_BITS-1:0] med3(input logic [SAMPLE_BITS-1:0] a,
                                                  input logic [SAMPLE_BITS-1:0] b,
                                                  input logic [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] mid;
    lo  = (a > b) ? b : a;
    hi  = (a > b) ? a : b;
    mid = (hi > c) ? c : hi;
    return (lo > mid) ? lo : mid;
  endfunction

  function automatic logic signed [WSUM_W-1:0] weight(input int ch);
    return WSUM_W'(2 * ch - (CHANNELS - 1));
  endfunction

endpackage

// ----- rtl/core/lsat_if.sv -----
interface lsat_frame_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_0;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_1;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_2;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_3;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_4;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_5;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_6;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_7;
  logic [lsat_pkg::CHANNELS-1:0]      digital_bits;

  modport source (output valid, mode, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, digital_bits, input ready);
  modport sink   (input valid, mode, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, digital_bits, output ready);
endinterface

interface lsat_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            line_state;
  logic signed [lsat_pkg::ERR_W-1:0]     position_error;
  logic signed [lsat_pkg::ERR_W-1:0]     smoothed_error;
  logic [lsat_pkg::DCNT_W-1:0]           dark_count;
  logic [lsat_pkg::EVT_W-1:0]            cross_count;

  modport source (output valid, line_state, position_error, smoothed_error, dark_count,
                  cross_count, input ready);
  modport sink   (input valid, line_state, position_error, smoothed_error, dark_count,
                  cross_count, output ready);
endinterface

interface lsat_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lsat_pkg::IDX_W-1:0]    index;
  logic [lsat_pkg::CFG_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lsat_lane.sv -----
module lsat_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lsat_pkg::lane_cmd_t                cmd_i,
  input  logic [lsat_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  logic                               bit_i,
  output logic [lsat_pkg::DARK_W-1:0]        dark_o,
  output logic                               done_o
);

  logic [lsat_pkg::SAMPLE_BITS-1:0]   white_q, black_q, hist1_q, hist2_q;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   h1, h2, r;
  logic signed [lsat_pkg::SAMPLE_BITS:0] num_s, span_s;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   num_mag, span_mag;
  logic [lsat_pkg::NUM_BITS-1:0]      quo_q;
  logic [lsat_pkg::SAMPLE_BITS-1:0]   rem_q, den_q, rem_d;
  logic [lsat_pkg::SAMPLE_BITS:0]     trial;
  logic                               fit;
  logic                               neg_q, flat_q, digital_q, bit_q, inv_q;
  logic [lsat_pkg::CFG_W-1:0]         floor_q;
  logic                               busy_q, fin_q, done_q;
  logic [lsat_pkg::LDIV_CNT_W-1:0]    step_q;
  logic signed [lsat_pkg::NUM_BITS+1:0] dv;
  logic [lsat_pkg::DARK_W-1:0]        dark_d, dark_q;

  always_comb begin
    h1       = cmd_i.seeded ? hist1_q : sample_i;
    h2       = cmd_i.seeded ? hist2_q : sample_i;
    r        = cmd_i.median ? lsat_pkg::med3(sample_i, h1, h2) : sample_i;
    num_s    = $signed({1'b0, white_q}) - $signed({1'b0, r});
    span_s   = $signed({1'b0, white_q}) - $signed({1'b0, black_q});
    num_mag  = num_s[lsat_pkg::SAMPLE_BITS] ? lsat_pkg::SAMPLE_BITS'(-num_s)
                                            : num_s[lsat_pkg::SAMPLE_BITS-1:0];
    span_mag = span_s[lsat_pkg::SAMPLE_BITS] ? lsat_pkg::SAMPLE_BITS'(-span_s)
                                             : span_s[lsat_pkg::SAMPLE_BITS-1:0];
  end

  always_comb begin
    trial = {rem_q, quo_q[lsat_pkg::NUM_BITS-1]};
    fit   = (trial >= {1'b0, den_q});
    rem_d = fit ? lsat_pkg::SAMPLE_BITS'(trial - {1'b0, den_q})
                : trial[lsat_pkg::SAMPLE_BITS-1:0];
  end

  always_comb begin
    if (flat_q) begin
      dv = '0;
    end else if (neg_q) begin
      dv = -$signed({2'b00, quo_q});
    end else begin
      dv = $signed({2'b00, quo_q});
    end
    if (inv_q) begin
      dv = $signed((lsat_pkg::NUM_BITS + 2)'(lsat_pkg::ONE_Q15)) - dv;
    end
    if (dv < 0) begin
      dark_d = '0;
    end else if (dv > $signed((lsat_pkg::NUM_BITS + 2)'(lsat_pkg::ONE_Q15))) begin
      dark_d = lsat_pkg::ONE_Q15;
    end else begin
      dark_d = dv[lsat_pkg::DARK_W-1:0];
    end
    if (dark_d < floor_q) begin
      dark_d = '0;
    end
    if (digital_q) begin
      dark_d = (bit_q ^ inv_q) ? lsat_pkg::ONE_Q15 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= lsat_pkg::WHITE_RESET;
      black_q <= lsat_pkg::BLACK_RESET;
      hist1_q <= '0;
      hist2_q <= '0;
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (cmd_i.start) begin
        case (cmd_i.mode)
          lsat_pkg::MODE_ANALOG: begin
            busy_q <= 1'b1;
            step_q <= '0;
            if (cmd_i.median) begin
              hist2_q <= h1;
              hist1_q <= sample_i;
            end else if (!cmd_i.seeded) begin
              hist2_q <= sample_i;
              hist1_q <= sample_i;
            end
          end
          lsat_pkg::MODE_DIGITAL: begin
            busy_q <= 1'b1;
            step_q <= '0;
          end
          lsat_pkg::MODE_CAL_WHITE: white_q <= sample_i;
          lsat_pkg::MODE_CAL_BLACK: black_q <= sample_i;
          default: ;
        endcase
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == lsat_pkg::LDIV_CNT_W'(lsat_pkg::NUM_BITS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q     <= {num_mag, {lsat_pkg::FRAC_Q15{1'b0}}};
      rem_q     <= '0;
      den_q     <= span_mag;
      neg_q     <= num_s[lsat_pkg::SAMPLE_BITS] ^ span_s[lsat_pkg::SAMPLE_BITS];
      flat_q    <= (span_mag <= lsat_pkg::SAMPLE_BITS'(1));
      digital_q <= (cmd_i.mode == lsat_pkg::MODE_DIGITAL);
      bit_q     <= bit_i;
      inv_q     <= cmd_i.invert;
      floor_q   <= cmd_i.floor_lvl;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[lsat_pkg::NUM_BITS-2:0], fit};
    end
    if (fin_q) begin
      dark_q <= dark_d;
    end
  end

  assign dark_o = dark_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/lsat_merge.sv -----
module lsat_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  lsat_pkg::mode_e              mode_i,
  input  lsat_pkg::cfg_t               cfg_i,
  input  logic [lsat_pkg::DARK_W-1:0]  dark_i [lsat_pkg::CHANNELS],
  input  logic                         lanes_done_i,
  input  logic                         out_free_i,
  output lsat_pkg::result_t            res_o,
  output logic                         emit_o,
  output logic                         idle_o
);

  lsat_pkg::mst_e st_q, st_d;

  logic [lsat_pkg::SUM_W-1:0]          sum_q, sum_d;
  logic signed [lsat_pkg::WSUM_W-1:0]  wsum_q, wsum_d;
  logic [lsat_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [lsat_pkg::WSUM_W-1:0]         wmag;
  logic [lsat_pkg::DEN_W-1:0]          den;
  logic                                is_lost, is_cross;

  logic [lsat_pkg::CEN_N_W-1:0]        n_q;
  logic [lsat_pkg::CEN_D_W-1:0]        rem_q, d_q, rem_d;
  logic [lsat_pkg::CEN_D_W:0]          trial;
  logic                                fit;
  logic [lsat_pkg::CDIV_CNT_W-1:0]     step_q;

  logic signed [lsat_pkg::ERR_W-1:0]   err_q;
  logic                                eneg_q;
  logic [lsat_pkg::ERR_W-1:0]          emag_q, qmag;
  logic [lsat_pkg::CFG_W-1:0]          k_sat, alpha_sat;
  logic [lsat_pkg::P1_W-1:0]           p1_q, lin_q;
  logic [lsat_pkg::P2_W-1:0]           p2_q;
  logic [lsat_pkg::ACC_W-1:0]          acc_q, cub_mag;

  logic signed [lsat_pkg::ERR_W:0]     diff;
  logic [lsat_pkg::ERR_W:0]            diff_mag;
  logic                                fneg_q;
  logic [lsat_pkg::FPROD_W-1:0]        fprod_q;
  logic [lsat_pkg::FPROD_W:0]          fstep;
  logic signed [lsat_pkg::ERR_W:0]     filt_next;

  logic                                dir_neg_q;
  logic [lsat_pkg::DEB_W-1:0]          deb_q;
  logic [lsat_pkg::EVT_W-1:0]          events_q;
  logic signed [lsat_pkg::ERR_W-1:0]   filt_q, last_err_q;
  lsat_pkg::line_e                     last_state_q;
  logic [lsat_pkg::DCNT_W-1:0]         last_dcnt_q;

  always_comb begin
    sum_d  = '0;
    wsum_d = '0;
    cnt_d  = '0;
    for (int c = 0; c < lsat_pkg::CHANNELS; c++) begin
      sum_d  = sum_d + lsat_pkg::SUM_W'(dark_i[c]);
      wsum_d = wsum_d + lsat_pkg::weight(c) *
               $signed({{(lsat_pkg::WSUM_W - lsat_pkg::DARK_W){1'b0}}, dark_i[c]});
      cnt_d  = cnt_d + lsat_pkg::CNT_W'(dark_i[c] > lsat_pkg::HALF_Q15);
    end
  end

  always_comb begin
    is_lost  = (cnt_q == '0);
    is_cross = (8'(cnt_q) >= 8'(cfg_i.thr));
    wmag     = wsum_q[lsat_pkg::WSUM_W-1] ? lsat_pkg::WSUM_W'(-wsum_q)
                                          : lsat_pkg::WSUM_W'(wsum_q);
    den      = lsat_pkg::DEN_W'(sum_q) * lsat_pkg::DEN_W'(lsat_pkg::CHANNELS - 1);
    trial    = {rem_q, n_q[lsat_pkg::CEN_N_W-1]};
    fit      = (trial >= {1'b0, d_q});
    rem_d    = fit ? lsat_pkg::CEN_D_W'(trial - {1'b0, d_q})
                   : trial[lsat_pkg::CEN_D_W-1:0];
    qmag     = n_q[lsat_pkg::ERR_W-1:0];
    k_sat     = (cfg_i.cubic > lsat_pkg::CFG_W'(lsat_pkg::ONE_Q15)) ?
                lsat_pkg::CFG_W'(lsat_pkg::ONE_Q15) : cfg_i.cubic;
    alpha_sat = (cfg_i.alpha > lsat_pkg::CFG_W'(lsat_pkg::ONE_Q15)) ?
                lsat_pkg::CFG_W'(lsat_pkg::ONE_Q15) : cfg_i.alpha;
    cub_mag  = (acc_q + (lsat_pkg::ACC_W'(1) << (lsat_pkg::CUB_SHIFT - 1)))
               >> lsat_pkg::CUB_SHIFT;
    diff     = $signed({err_q[lsat_pkg::ERR_W-1], err_q}) -
               $signed({filt_q[lsat_pkg::ERR_W-1], filt_q});
    diff_mag = diff[lsat_pkg::ERR_W] ? (lsat_pkg::ERR_W + 1)'(-diff)
                                     : (lsat_pkg::ERR_W + 1)'(diff);
    fstep    = (lsat_pkg::FPROD_W + 1)'(fprod_q) +
               (lsat_pkg::FPROD_W + 1)'(lsat_pkg::HALF_Q15);
    filt_next = fneg_q ?
      $signed({filt_q[lsat_pkg::ERR_W-1], filt_q}) -
        $signed((lsat_pkg::ERR_W + 1)'(fstep >> lsat_pkg::FRAC_Q15)) :
      $signed({filt_q[lsat_pkg::ERR_W-1], filt_q}) +
        $signed((lsat_pkg::ERR_W + 1)'(fstep >> lsat_pkg::FRAC_Q15));
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      lsat_pkg::MST_IDLE: begin
        if (start_i) begin
          if (mode_i == lsat_pkg::MODE_ANALOG || mode_i == lsat_pkg::MODE_DIGITAL) begin
            st_d = lsat_pkg::MST_LANES;
          end else begin
            st_d = lsat_pkg::MST_EMIT;
          end
        end
      end
      lsat_pkg::MST_LANES:   if (lanes_done_i) st_d = lsat_pkg::MST_SUM;
      lsat_pkg::MST_SUM:     st_d = lsat_pkg::MST_CLASS;
      lsat_pkg::MST_CLASS:   st_d = (is_lost || is_cross) ? lsat_pkg::MST_FILT_MUL
                                                          : lsat_pkg::MST_DIV;
      lsat_pkg::MST_DIV: begin
        if (step_q == lsat_pkg::CDIV_CNT_W'(lsat_pkg::CEN_N_W - 1)) begin
          st_d = lsat_pkg::MST_DIV_END;
        end
      end
      lsat_pkg::MST_DIV_END: st_d = (cfg_i.cubic != '0) ? lsat_pkg::MST_CUB_SQ
                                                        : lsat_pkg::MST_FILT_MUL;
      lsat_pkg::MST_CUB_SQ:   st_d = lsat_pkg::MST_CUB_CU;
      lsat_pkg::MST_CUB_CU:   st_d = lsat_pkg::MST_CUB_LO;
      lsat_pkg::MST_CUB_LO:   st_d = lsat_pkg::MST_CUB_HI;
      lsat_pkg::MST_CUB_HI:   st_d = lsat_pkg::MST_CUB_END;
      lsat_pkg::MST_CUB_END:  st_d = lsat_pkg::MST_FILT_MUL;
      lsat_pkg::MST_FILT_MUL: st_d = lsat_pkg::MST_FILT_ADD;
      lsat_pkg::MST_FILT_ADD: st_d = lsat_pkg::MST_EMIT;
      lsat_pkg::MST_EMIT:     if (out_free_i) st_d = lsat_pkg::MST_IDLE;
      default:                st_d = lsat_pkg::MST_IDLE;
    endcase
  end

  always_comb begin
    idle_o = (st_q == lsat_pkg::MST_IDLE);
    emit_o = (st_q == lsat_pkg::MST_EMIT) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= lsat_pkg::MST_IDLE;
      dir_neg_q    <= 1'b0;
      deb_q        <= '0;
      events_q     <= '0;
      filt_q       <= '0;
      last_err_q   <= '0;
      last_state_q <= lsat_pkg::LINE_ON;
      last_dcnt_q  <= '0;
      step_q       <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        lsat_pkg::MST_CLASS: begin
          last_dcnt_q <= lsat_pkg::DCNT_W'(cnt_q);
          step_q      <= '0;
          if (is_lost) begin
            last_state_q <= lsat_pkg::LINE_LOST;
            deb_q        <= (deb_q != '0) ? deb_q - 1'b1 : deb_q;
          end else if (is_cross) begin
            last_state_q <= lsat_pkg::LINE_CROSS;
            deb_q        <= lsat_pkg::DEB_W'(lsat_pkg::DEBOUNCE_FRAMES - 1);
            if (deb_q == '0) begin
              events_q <= events_q + 1'b1;
            end
          end else begin
            last_state_q <= lsat_pkg::LINE_ON;
            deb_q        <= (deb_q != '0) ? deb_q - 1'b1 : deb_q;
          end
        end
        lsat_pkg::MST_DIV: step_q <= step_q + 1'b1;
        lsat_pkg::MST_FILT_MUL: begin
          if (last_state_q == lsat_pkg::LINE_ON) begin
            if (err_q > lsat_pkg::DIR_BAND) dir_neg_q <= 1'b0;
            if (err_q < -lsat_pkg::DIR_BAND) dir_neg_q <= 1'b1;
          end
        end
        lsat_pkg::MST_FILT_ADD: begin
          filt_q     <= filt_next[lsat_pkg::ERR_W-1:0];
          last_err_q <= err_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      lsat_pkg::MST_SUM: begin
        sum_q  <= sum_d;
        wsum_q <= wsum_d;
        cnt_q  <= cnt_d;
      end
      lsat_pkg::MST_CLASS: begin
        if (is_lost) begin
          err_q <= dir_neg_q ? -lsat_pkg::ONE_Q14 : lsat_pkg::ONE_Q14;
        end else begin
          err_q <= '0;
        end
        n_q   <= lsat_pkg::CEN_N_W'({wmag, {lsat_pkg::FRAC_Q15{1'b0}}}) +
                 lsat_pkg::CEN_N_W'(den);
        d_q   <= {den, 1'b0};
        rem_q <= '0;
      end
      lsat_pkg::MST_DIV: begin
        rem_q <= rem_d;
        n_q   <= {n_q[lsat_pkg::CEN_N_W-2:0], fit};
      end
      lsat_pkg::MST_DIV_END: begin
        eneg_q <= wsum_q[lsat_pkg::WSUM_W-1];
        emag_q <= qmag;
        err_q  <= wsum_q[lsat_pkg::WSUM_W-1] ? -$signed(qmag) : $signed(qmag);
      end
      lsat_pkg::MST_CUB_SQ: begin
        p1_q  <= emag_q * emag_q;
        lin_q <= (lsat_pkg::CFG_W'(lsat_pkg::ONE_Q15) - k_sat) * emag_q;
      end
      lsat_pkg::MST_CUB_CU: p2_q <= lsat_pkg::P2_W'(p1_q) * lsat_pkg::P2_W'(emag_q);
      lsat_pkg::MST_CUB_LO: begin
        acc_q <= (lsat_pkg::ACC_W'(lin_q) << lsat_pkg::LIN_SHIFT) +
                 lsat_pkg::ACC_W'(p2_q[lsat_pkg::CUB_SPLIT-1:0]) *
                 lsat_pkg::ACC_W'(k_sat);
      end
      lsat_pkg::MST_CUB_HI: begin
        acc_q <= acc_q +
                 ((lsat_pkg::ACC_W'(p2_q[lsat_pkg::P2_W-1:lsat_pkg::CUB_SPLIT]) *
                   lsat_pkg::ACC_W'(k_sat)) << lsat_pkg::CUB_SPLIT);
      end
      lsat_pkg::MST_CUB_END: begin
        err_q <= eneg_q ? -$signed(cub_mag[lsat_pkg::ERR_W-1:0])
                        : $signed(cub_mag[lsat_pkg::ERR_W-1:0]);
      end
      lsat_pkg::MST_FILT_MUL: begin
        fneg_q  <= diff[lsat_pkg::ERR_W];
        fprod_q <= alpha_sat * diff_mag[lsat_pkg::ERR_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.state  = last_state_q;
    res_o.err    = last_err_q;
    res_o.filt   = filt_q;
    res_o.dcnt   = last_dcnt_q;
    res_o.events = events_q;
  end

endmodule

// ----- rtl/core/line_sensor_array_tracker.sv -----
// Path, accept to result valid: lost and cross frames skip the centroid divider;
// on-line frames use it, and the cubic states too when the cubic gain is set;
// calibration frames go straight to emit. Lanes and the centroid divider each make
// one quotient bit per cycle. One frame at a time: the next frame is taken once
// the result enters the output register, which waits while the sink holds off a pending result.
// Reset: asynchronous, active low; calibration levels, history and filter restart.
module line_sensor_array_tracker (
  input logic             clk_i,
  input logic             rst_ni,
  lsat_frame_if.sink      frame_i,
  lsat_result_if.source   result_o,
  lsat_cfg_if.sink        cfg_i
);

  lsat_pkg::cfg_t      cfg_q;
  lsat_pkg::lane_cmd_t cmd;
  lsat_pkg::result_t   res, res_q;
  logic                seeded_q;
  logic                accept, idle, emit, out_valid_q, out_free;
  logic [lsat_pkg::SAMPLE_BITS-1:0] samples [lsat_pkg::CHANNELS];
  logic [lsat_pkg::DARK_W-1:0]      dark [lsat_pkg::CHANNELS];
  logic [lsat_pkg::CHANNELS-1:0]    lane_done;

  assign cfg_i.ready   = 1'b1;
  assign frame_i.ready = idle;
  assign accept        = frame_i.valid && idle;
  assign out_free      = !out_valid_q || result_o.ready;

  assign samples[0] = frame_i.sample_0;
  assign samples[1] = frame_i.sample_1;
  assign samples[2] = frame_i.sample_2;
  assign samples[3] = frame_i.sample_3;
  assign samples[4] = frame_i.sample_4;
  assign samples[5] = frame_i.sample_5;
  assign samples[6] = frame_i.sample_6;
  assign samples[7] = frame_i.sample_7;

  always_comb begin
    cmd.start     = accept;
    cmd.mode      = lsat_pkg::mode_e'(frame_i.mode);
    cmd.seeded    = seeded_q;
    cmd.median    = cfg_q.median;
    cmd.invert    = cfg_q.invert;
    cmd.floor_lvl = cfg_q.floor_lvl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= lsat_pkg::ALPHA_RESET;
      cfg_q.thr       <= lsat_pkg::THR_RESET;
      cfg_q.invert    <= 1'b0;
      cfg_q.floor_lvl <= lsat_pkg::FLOOR_RESET;
      cfg_q.median    <= 1'b1;
      cfg_q.cubic     <= '0;
      seeded_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (lsat_pkg::reg_e'(cfg_i.index))
          lsat_pkg::REG_ALPHA:  cfg_q.alpha     <= cfg_i.data;
          lsat_pkg::REG_THR:    cfg_q.thr       <= cfg_i.data[lsat_pkg::THR_W-1:0];
          lsat_pkg::REG_INVERT: cfg_q.invert    <= cfg_i.data[0];
          lsat_pkg::REG_FLOOR:  cfg_q.floor_lvl <= cfg_i.data;
          lsat_pkg::REG_MEDIAN: cfg_q.median    <= cfg_i.data[0];
          lsat_pkg::REG_CUBIC:  cfg_q.cubic     <= cfg_i.data;
          default: ;
        endcase
      end
      if (accept && frame_i.mode == lsat_pkg::MODE_ANALOG) begin
        seeded_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  for (genvar c = 0; c < lsat_pkg::CHANNELS; c++) begin : g_lane
    lsat_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sample_i(samples[c]),
      .bit_i   (frame_i.digital_bits[c]),
      .dark_o  (dark[c]),
      .done_o  (lane_done[c])
    );
  end

  lsat_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .mode_i      (lsat_pkg::mode_e'(frame_i.mode)),
    .cfg_i       (cfg_q),
    .dark_i      (dark),
    .lanes_done_i(&lane_done),
    .out_free_i  (out_free),
    .res_o       (res),
    .emit_o      (emit),
    .idle_o      (idle)
  );

  assign result_o.valid          = out_valid_q;
  assign result_o.line_state     = res_q.state;
  assign result_o.position_error = res_q.err;
  assign result_o.smoothed_error = res_q.filt;
  assign result_o.dark_count     = res_q.dcnt;
  assign result_o.cross_count    = res_q.events;

endmodule

// ----- rtl/core/lsat_checker.sv -----
module lsat_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               frame_valid_i,
  input logic                               frame_ready_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic [1:0]                         line_state_i,
  input logic signed [lsat_pkg::ERR_W-1:0]  position_error_i,
  input logic [lsat_pkg::DCNT_W-1:0]        dark_count_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && frame_ready_i |=> !frame_ready_i)
    else $error("frame taken while one is in flight");

  a_cross_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && line_state_i == lsat_pkg::LINE_CROSS |-> position_error_i == '0)
    else $error("cross frame with nonzero error");

  a_lost_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && line_state_i == lsat_pkg::LINE_LOST |->
      (position_error_i == lsat_pkg::ONE_Q14 || position_error_i == -lsat_pkg::ONE_Q14))
    else $error("lost frame without full-scale error");

  a_dark_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> 8'(dark_count_i) <= 8'(lsat_pkg::CHANNELS))
    else $error("dark count above channel count");

endmodule

bind line_sensor_array_tracker lsat_checker u_lsat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .frame_valid_i   (frame_i.valid),
  .frame_ready_i   (frame_i.ready),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .line_state_i    (result_o.line_state),
  .position_error_i(result_o.position_error),
  .dark_count_i    (result_o.dark_count)
);

// ----- tb/sv/testbench.sv -----
module testbench;
  import lsat_pkg::*;

  typedef struct packed {
    mode_e                       mode;
    logic [7:0][SAMPLE_BITS-1:0] smp;
    logic [7:0]                  bits;
  } frame_t;

  typedef struct packed {
    frame_t  f;
    logic    known;
    result_t want;
  } row_t;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;

  lsat_frame_if  frame_bus ();
  lsat_result_if result_bus ();
  lsat_cfg_if    cfg_bus ();

  line_sensor_array_tracker u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // tracker model state
  logic [SAMPLE_BITS-1:0] white_lvl [8];
  logic [SAMPLE_BITS-1:0] black_lvl [8];
  logic [SAMPLE_BITS-1:0] tap_one [8];
  logic [SAMPLE_BITS-1:0] tap_two [8];
  logic       taps_seeded;
  logic       heading_neg;
  int         debounce_left;
  logic [15:0] crossings;
  int         smooth_err;
  line_e      prev_state;
  int         prev_err;
  int         prev_dcnt;

  logic [15:0] alpha_q, floor_q, cubic_q;
  logic [3:0]  thr_q;
  logic        invert_q, median_q;

  result_t result_q [$];
  int      errors;
  int      frames_taken;
  logic    calm;
  logic    hold_rx;
  logic    hold_armed;
  int      quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] mid_of(logic [SAMPLE_BITS-1:0] a,
                                                    logic [SAMPLE_BITS-1:0] b,
                                                    logic [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  task automatic tracker_reset();
    for (int i = 0; i < 8; i++) begin
      white_lvl[i] = 12'd3500;
      black_lvl[i] = 12'd500;
      tap_one[i] = '0;
      tap_two[i] = '0;
    end
    taps_seeded = 1'b0;
    heading_neg = 1'b0;
    debounce_left = 0;
    crossings = '0;
    smooth_err = 0;
    prev_state = LINE_ON;
    prev_err = 0;
    prev_dcnt = 0;
    alpha_q = 16'd19661;
    thr_q = 4'd6;
    invert_q = 1'b0;
    floor_q = 16'd4915;
    median_q = 1'b1;
    cubic_q = 16'd0;
  endtask

  function automatic void settle_frame(longint dk [8]);
    longint sum, wsum, k, e, num, a;
    int     cnt;
    int     err;
    sum = 0;
    wsum = 0;
    cnt = 0;
    for (int i = 0; i < 8; i++) begin
      if (dk[i] > 16384) cnt++;
      sum += dk[i];
      wsum += dk[i] * (2 * i - 7);
    end
    if (cnt == 0) begin
      prev_state = LINE_LOST;
      err = heading_neg ? -16384 : 16384;
    end else if (cnt >= thr_q) begin
      prev_state = LINE_CROSS;
      err = 0;
      if (debounce_left == 0) crossings = crossings + 16'd1;
      debounce_left = DEBOUNCE_FRAMES;
    end else begin
      prev_state = LINE_ON;
      err = int'(round_div(wsum * 16384, sum * 7));
      if (cubic_q != 0) begin
        k = (cubic_q > 16'd32768) ? 32768 : longint'(cubic_q);
        e = err;
        num = (32768 - k) * e * (longint'(1) << 28) + k * (e * e * e);
        err = int'(round_div(num, longint'(1) << 43));
      end
      if (err > 819) heading_neg = 1'b0;
      if (err < -819) heading_neg = 1'b1;
    end
    if (debounce_left != 0) debounce_left--;
    a = (alpha_q > 16'd32768) ? 32768 : longint'(alpha_q);
    smooth_err += int'(round_div(a * (err - smooth_err), 32768));
    prev_err = err;
    prev_dcnt = cnt & 15;
  endfunction

  function automatic result_t track_frame(frame_t f);
    longint dk [8];
    longint span, d;
    logic [SAMPLE_BITS-1:0] r;
    logic on;
    result_t res;
    case (f.mode)
      MODE_ANALOG: begin
        if (!taps_seeded) begin
          for (int i = 0; i < 8; i++) begin
            tap_one[i] = f.smp[i];
            tap_two[i] = f.smp[i];
          end
          taps_seeded = 1'b1;
        end
        for (int i = 0; i < 8; i++) begin
          r = f.smp[i];
          if (median_q) begin
            r = mid_of(f.smp[i], tap_one[i], tap_two[i]);
            tap_two[i] = tap_one[i];
            tap_one[i] = f.smp[i];
          end
          span = longint'(white_lvl[i]) - longint'(black_lvl[i]);
          if (span > 1 || span < -1) d = ((longint'(white_lvl[i]) - longint'(r)) * 32768) / span;
          else d = 0;
          if (invert_q) d = 32768 - d;
          if (d < 0) d = 0;
          if (d > 32768) d = 32768;
          if (d < longint'(floor_q)) d = 0;
          dk[i] = d;
        end
        settle_frame(dk);
      end
      MODE_DIGITAL: begin
        for (int i = 0; i < 8; i++) begin
          on = f.bits[i] ^ invert_q;
          dk[i] = on ? 32768 : 0;
        end
        settle_frame(dk);
      end
      MODE_CAL_WHITE: for (int i = 0; i < 8; i++) white_lvl[i] = f.smp[i];
      default:        for (int i = 0; i < 8; i++) black_lvl[i] = f.smp[i];
    endcase
    res.state = prev_state;
    res.err = 16'(prev_err);
    res.filt = 16'(smooth_err);
    res.dcnt = 4'(prev_dcnt);
    res.events = crossings;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // accept side: predict at the request handshake, compare at the result handshake
  row_t pending [$];
  always @(posedge clk_i) begin
    result_t want;
    result_t model;
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      model = track_frame(pending[0].f);
      want = pending[0].known ? pending[0].want : model;
      void'(pending.pop_front());
      result_q.push_back(want);
      frames_taken <= frames_taken + 1;
    end
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = result_q.pop_front();
        if (result_bus.line_state != want.state)
          report("line_state", result_bus.line_state, want.state);
        if (result_bus.position_error != want.err)
          report("position_error", result_bus.position_error, want.err);
        if (result_bus.smoothed_error != want.filt)
          report("smoothed_error", result_bus.smoothed_error, want.filt);
        if (result_bus.dark_count != want.dcnt)
          report("dark_count", result_bus.dark_count, want.dcnt);
        if (result_bus.cross_count != want.events)
          report("cross_count", result_bus.cross_count, want.events);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_rx) result_bus.ready <= 1'b0;
    else if (calm) result_bus.ready <= 1'b1;
    else result_bus.ready <= ($urandom_range(99) >= 27);
  end

  initial begin
    hold_rx = 1'b0;
    wait (hold_armed);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_frame(row_t r);
    while (!calm && $urandom_range(99) < 27) begin
      frame_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pending.push_back(r);
    frame_bus.valid <= 1'b1;
    frame_bus.mode <= r.f.mode;
    frame_bus.sample_0 <= r.f.smp[0];
    frame_bus.sample_1 <= r.f.smp[1];
    frame_bus.sample_2 <= r.f.smp[2];
    frame_bus.sample_3 <= r.f.smp[3];
    frame_bus.sample_4 <= r.f.smp[4];
    frame_bus.sample_5 <= r.f.smp[5];
    frame_bus.sample_6 <= r.f.smp[6];
    frame_bus.sample_7 <= r.f.smp[7];
    frame_bus.digital_bits <= r.f.bits;
    @(posedge clk_i);
    while (!frame_bus.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_ALPHA:  alpha_q = val;
      REG_THR:    thr_q = val[3:0];
      REG_INVERT: invert_q = val[0];
      REG_FLOOR:  floor_q = val;
      REG_MEDIAN: median_q = val[0];
      default:    cubic_q = val;
    endcase
  endtask

  task automatic drain();
    frame_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0 || pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] alpha, logic [15:0] thr, logic [15:0] inv,
                           logic [15:0] flr, logic [15:0] med, logic [15:0] cub);
    drain();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_THR, thr);
    write_reg(REG_INVERT, inv);
    write_reg(REG_FLOOR, flr);
    write_reg(REG_MEDIAN, med);
    write_reg(REG_CUBIC, cub);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic row_t flat(mode_e m, int s, logic [7:0] bits);
    row_t r;
    r = '0;
    r.f.mode = m;
    for (int i = 0; i < 8; i++) r.f.smp[i] = 12'(s);
    r.f.bits = bits;
    return r;
  endfunction

  function automatic row_t random_frame();
    row_t r;
    int   pick, c, w;
    logic [7:0] band;
    r = '0;
    pick = $urandom_range(99);
    c = $urandom_range(7);
    w = $urandom_range(3);
    band = '0;
    for (int i = 0; i < 8; i++) band[i] = ((i >= c - w) && (i <= c + w));
    if (pick < 50) r.f.mode = MODE_ANALOG;
    else if (pick < 85) r.f.mode = MODE_DIGITAL;
    else if (pick < 93) r.f.mode = MODE_CAL_WHITE;
    else r.f.mode = MODE_CAL_BLACK;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(9) == 0) r.f.smp[i] = 12'($urandom);
      else if (r.f.mode == MODE_CAL_WHITE) r.f.smp[i] = 12'($urandom_range(3000, 4095));
      else if (r.f.mode == MODE_CAL_BLACK) r.f.smp[i] = 12'($urandom_range(0, 1000));
      else if (band[i]) r.f.smp[i] = 12'($urandom_range(0, 1200));
      else r.f.smp[i] = 12'($urandom_range(2800, 4095));
    end
    r.f.bits = ($urandom_range(1) == 0) ? band : 8'($urandom);
    return r;
  endfunction

  initial begin
    row_t rows [$];
    row_t r;
    rst_ni = 1'b0;
    frame_bus.valid = 1'b0;
    frame_bus.mode = '0;
    frame_bus.sample_0 = '0;
    frame_bus.sample_1 = '0;
    frame_bus.sample_2 = '0;
    frame_bus.sample_3 = '0;
    frame_bus.sample_4 = '0;
    frame_bus.sample_5 = '0;
    frame_bus.sample_6 = '0;
    frame_bus.sample_7 = '0;
    frame_bus.digital_bits = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    errors = 0;
    frames_taken = 0;
    calm = 1'b0;
    hold_armed = 1'b0;
    quiet_cycles = 0;
    tracker_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r = flat(MODE_CAL_WHITE, 3500, 8'h00);
    r.known = 1'b1;
    r.want = '{LINE_ON, 16'sd0, 16'sd0, 4'd0, 16'd0};
    rows.push_back(r);
    r = flat(MODE_DIGITAL, 0, 8'h00);
    r.known = 1'b1;
    r.want = '{LINE_LOST, 16'sd16384, 16'sd9831, 4'd0, 16'd0};
    rows.push_back(r);
    rows.push_back(flat(MODE_DIGITAL, 4095, 8'hFF));
    rows.push_back(flat(MODE_DIGITAL, 0, 8'h01));
    rows.push_back(flat(MODE_DIGITAL, 0, 8'h80));
    rows.push_back(flat(MODE_DIGITAL, 0, 8'h18));
    rows.push_back(flat(MODE_DIGITAL, 0, 8'h55));
    rows.push_back(flat(MODE_DIGITAL, 0, 8'hAA));
    r = flat(MODE_ANALOG, 0, 8'h00);
    r.f.smp = {12'd1000, 12'd2000, 12'd3500, 12'd500, 12'd4095, 12'd0, 12'd4095, 12'd0};
    rows.push_back(r);
    rows.push_back(flat(MODE_ANALOG, 4095, 8'h00));
    rows.push_back(flat(MODE_ANALOG, 0, 8'h00));
    rows.push_back(flat(MODE_ANALOG, 500, 8'h00));
    r = flat(MODE_ANALOG, 3500, 8'h00);
    r.f.smp[3] = 12'd500;
    r.f.smp[4] = 12'd600;
    rows.push_back(r);
    rows.push_back(r);
    rows.push_back(flat(MODE_CAL_WHITE, 2000, 8'h00));
    rows.push_back(flat(MODE_CAL_BLACK, 2000, 8'h00));
    rows.push_back(flat(MODE_ANALOG, 0, 8'h00));
    rows.push_back(flat(MODE_CAL_BLACK, 2001, 8'h00));
    rows.push_back(flat(MODE_ANALOG, 4095, 8'h00));
    rows.push_back(flat(MODE_CAL_BLACK, 4095, 8'h00));
    rows.push_back(r);
    rows.push_back(flat(MODE_CAL_WHITE, 3500, 8'h00));
    rows.push_back(flat(MODE_CAL_BLACK, 500, 8'h00));
    foreach (rows[i]) send_frame(rows[i]);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure(16'd19661, 16'd6, 16'd0, 16'd4915, 16'd1, 16'd0);
        1: configure(16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd32768);
        2: configure(16'd32768, 16'd8, 16'd0, 16'd32768, 16'd1, 16'd1);
        3: configure(16'd65535, 16'd0, 16'd1, 16'd65535, 16'd1, 16'd65535);
        default: configure(16'd8000, 16'd15, 16'd0, 16'd2000, 16'd0, 16'd16384);
      endcase
      for (int n = 0; n < 370; n++) begin
        if (phase == 0 && n == 60) hold_armed = 1'b1;
        calm = (phase == 2 && n >= 100 && n < 250);
        send_frame(random_frame());
      end
    end
    calm = 1'b0;
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- line_sensor_array_tracker.f -----
rtl/core/lsat_pkg.sv
rtl/core/lsat_if.sv
rtl/core/lsat_lane.sv
rtl/core/lsat_merge.sv
rtl/core/line_sensor_array_tracker.sv
rtl/core/lsat_checker.sv
tb/sv/testbench.sv
